FILE: hw/rtl/noc_router_output_port_select_top_macros.svh
// Assertion helpers used by nrps_back.
`ifndef NOC_ROUTER_OUTPUT_PORT_SELECT_TOP_MACROS_SVH
`define NOC_ROUTER_OUTPUT_PORT_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("routing unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NRPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("routing unit assertion failed");

`endif

FILE: hw/rtl/nrps_pkg.sv
package nrps_pkg;

    localparam int NUM_VNETS_DEF = 4;
    localparam int NUM_LINKS_DEF = 16;
    localparam int DEST_BITS_DEF = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 16;

    localparam logic [1:0] OP_ROUTE  = 2'd0;
    localparam logic [1:0] OP_WR_SET = 2'd1;
    localparam logic [1:0] OP_WR_WT  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_XY    = 2'd1;
    localparam logic [1:0] MODE_RING  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [2:0] REG_ROUTING_MODE    = 3'd0;
    localparam logic [2:0] REG_NODE_ID         = 3'd1;
    localparam logic [2:0] REG_MESH_COLUMNS    = 3'd2;
    localparam logic [2:0] REG_RING_SIZE       = 3'd3;
    localparam logic [2:0] REG_ORDERED_VNETS   = 3'd4;
    localparam logic [2:0] REG_LINKS_IN_USE    = 3'd5;
    localparam logic [2:0] REG_DIRECTION_PORTS = 3'd6;

    typedef enum logic [2:0] {
        CMD_WR_SET,
        CMD_WR_WT,
        CMD_TABLE,
        CMD_XY,
        CMD_RING
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  vnet;
        logic [3:0]  link;
        logic [63:0] dest_set;
        logic [7:0]  weight;
        logic [7:0]  dst_node;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN1,
        ST_EVAL,
        ST_PICK,
        ST_SCAN2,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } st_t;

endpackage

FILE: hw/rtl/nrps_front.sv
module nrps_front import nrps_pkg::*; #(
    parameter int NUM_VNETS = NUM_VNETS_DEF,
    parameter int NUM_LINKS = NUM_LINKS_DEF
) (
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_op,
    input  logic [1:0]   s_vnet,
    input  logic [3:0]   s_link,
    input  logic [63:0]  s_dest_set,
    input  logic [7:0]   s_weight,
    input  logic [7:0]   s_dst_node,
    input  logic [1:0]   routing_mode,
    input  logic [7:0]   node_id,
    input  back_status_t back_status,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);

    logic      keep;
    cmd_kind_t kind;

    always_comb begin
        keep = 1'b0;
        kind = CMD_TABLE;
        unique case (s_op)
            OP_WR_SET: begin
                keep = (32'(s_vnet) < NUM_VNETS) && (32'(s_link) < NUM_LINKS);
                kind = CMD_WR_SET;
            end
            OP_WR_WT: begin
                keep = 32'(s_link) < NUM_LINKS;
                kind = CMD_WR_WT;
            end
            OP_ROUTE: begin
                keep = 1'b1;
                if (s_dst_node == node_id) begin
                    kind = CMD_TABLE;
                end else if (routing_mode == MODE_XY) begin
                    kind = CMD_XY;
                end else if (routing_mode == MODE_RING) begin
                    kind = CMD_RING;
                end else begin
                    kind = CMD_TABLE;
                end
            end
            default: begin
                keep = 1'b0;
                kind = CMD_TABLE;
            end
        endcase
    end

    assign s_ready = !q_full && !back_status.clearing;
    assign q_push  = s_valid && s_ready && keep;

    always_comb begin
        q_cmd.kind        = kind;
        q_cmd.vnet        = s_vnet;
        q_cmd.link        = s_link;
        q_cmd.dest_set    = s_dest_set;
        q_cmd.weight      = s_weight;
        q_cmd.dst_node    = s_dst_node;
    end

endmodule

FILE: hw/rtl/nrps_fifo.sv
module nrps_fifo import nrps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic valid,
    output logic full,
    output cmd_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign valid = count_reg != '0;
    assign full  = 32'(count_reg) == QUEUE_DEPTH;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/nrps_div.sv
module nrps_div import nrps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [8:0]  divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [8:0]  remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  step_reg;
    logic [15:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [8:0]  dvs_reg;
    logic [9:0]  shifted;
    logic        fits;
    logic [8:0]  rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[15]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? 9'(shifted - {1'b0, dvs_reg}) : shifted[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 4'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[14:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/nrps_back.sv
module nrps_back import nrps_pkg::*; #(
    parameter int NUM_VNETS = NUM_VNETS_DEF,
    parameter int NUM_LINKS = NUM_LINKS_DEF,
    parameter int DEST_BITS = DEST_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  cmd_t         q_head,
    output logic         q_pop,
    output back_status_t back_status,
    input  logic [7:0]   node_id,
    input  logic [7:0]   mesh_columns,
    input  logic [8:0]   ring_size,
    input  logic [3:0]   ordered_vnets,
    input  logic [4:0]   links_in_use,
    input  logic [23:0]  direction_ports,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [3:0]   m_out_port,
    output logic         m_no_route
);

    `include "noc_router_output_port_select_top_macros.svh"

    localparam int DEPTH = NUM_VNETS * NUM_LINKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int NW    = $clog2(NUM_LINKS + 1);

    logic [DEST_BITS-1:0] set_mem [DEPTH];
    logic [7:0]           wt_mem  [NUM_LINKS];

    st_t                  state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [AW-1:0]        clr_idx_reg;
    logic [NW-1:0]        scan_idx_reg;
    logic                 proc_vld_reg;
    logic [LW-1:0]        proc_idx_reg;
    logic [DEST_BITS-1:0] set_rd_reg;
    logic [7:0]           wt_rd_reg;
    logic [8:0]           min_reg;
    logic [NW-1:0]        cnt_reg;
    logic [LW-1:0]        first_reg;
    logic [NW-1:0]        pick_reg;
    logic [NW-1:0]        k_reg;
    logic                 found_reg;
    logic [15:0]          lfsr_reg;
    logic [7:0]           q1_reg;
    logic [8:0]           r1_reg;
    logic [3:0]           res_port_reg;
    logic                 res_nr_reg;
    logic                 m_valid_reg;
    logic [3:0]           m_port_reg;
    logic                 m_nr_reg;

    logic                 clr_last;
    logic [NW-1:0]        n_links;
    logic                 scanning;
    logic                 scan_issue;
    logic                 scan_done;
    logic                 hit;
    logic                 hit_min;
    logic [AW-1:0]        rd_addr;
    logic [15:0]          lfsr_nxt;
    logic                 ordered;
    logic [8:0]           cols9;
    logic [8:0]           ring9;
    logic                 div_start;
    logic [15:0]          div_dividend;
    logic [8:0]           div_divisor;
    logic                 div_done;
    logic [15:0]          div_quo;
    logic [8:0]           div_rem;
    logic                 out_free;
    logic [7:0]           dx, dy;
    logic [9:0]           cw, ccw;
    logic [3:0]           dir_port;

    assign clr_last = 32'(clr_idx_reg) == DEPTH - 1;
    assign out_free = !m_valid_reg || m_ready;
    assign cols9    = (mesh_columns == 8'd0) ? 9'd1 : {1'b0, mesh_columns};
    assign ring9    = (ring_size == 9'd0) ? 9'd1 : ring_size;
    assign ordered  = ordered_vnets[cmd_reg.vnet];
    assign lfsr_nxt = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};

    always_comb begin
        if (32'(cmd_reg.vnet) >= NUM_VNETS) begin
            n_links = '0;
        end else if (32'(links_in_use) > NUM_LINKS) begin
            n_links = NW'(NUM_LINKS);
        end else begin
            n_links = NW'(links_in_use);
        end
    end

    assign scanning   = (state_reg == ST_SCAN1) || (state_reg == ST_SCAN2);
    assign scan_issue = scan_idx_reg < n_links;
    assign scan_done  = !scan_issue && !proc_vld_reg;
    assign rd_addr    = AW'(32'(cmd_reg.vnet) * NUM_LINKS + 32'(scan_idx_reg[LW-1:0]));
    assign hit        = proc_vld_reg && (|(cmd_reg.dest_set[DEST_BITS-1:0] & set_rd_reg));
    assign hit_min    = hit && ({1'b0, wt_rd_reg} == min_reg);

    nrps_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.kind) inside
                        CMD_TABLE:             state_next = ST_SCAN1;
                        CMD_XY, CMD_RING:      state_next = ST_DIV1;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN1: begin
                if (scan_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (cnt_reg == '0 || ordered) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (div_done) begin
                    state_next = ST_SCAN2;
                end
            end
            ST_SCAN2: begin
                if (scan_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop                = (state_reg == ST_IDLE) && q_valid;
        back_status.clearing = state_reg == ST_CLEAR;
        div_start            = 1'b0;
        div_dividend         = {8'd0, node_id};
        div_divisor          = (cmd_reg.kind == CMD_XY) ? cols9 : ring9;
        unique case (state_reg)
            ST_IDLE: begin
                div_start   = q_valid && (q_head.kind == CMD_XY || q_head.kind == CMD_RING);
                div_divisor = (q_head.kind == CMD_XY) ? cols9 : ring9;
            end
            ST_DIV1: begin
                div_start    = div_done;
                div_dividend = {8'd0, cmd_reg.dst_node};
            end
            ST_EVAL: begin
                div_start    = (cnt_reg != '0) && !ordered;
                div_dividend = lfsr_nxt;
                div_divisor  = 9'(cnt_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        dx = div_rem[7:0];
        dy = div_quo[7:0];
        if (div_rem >= r1_reg) begin
            cw = {1'b0, div_rem - r1_reg};
        end else begin
            cw = 10'({1'b0, div_rem} + {1'b0, ring9} - {1'b0, r1_reg});
        end
        if (r1_reg >= div_rem) begin
            ccw = {1'b0, r1_reg - div_rem};
        end else begin
            ccw = 10'({1'b0, r1_reg} + {1'b0, ring9} - {1'b0, div_rem});
        end
        if (cmd_reg.kind == CMD_XY) begin
            if (dx != r1_reg[7:0]) begin
                dir_port = (dx > r1_reg[7:0]) ? direction_ports[3:0] : direction_ports[7:4];
            end else begin
                dir_port = (dy >= q1_reg) ? direction_ports[11:8] : direction_ports[15:12];
            end
        end else begin
            dir_port = (cw <= ccw) ? direction_ports[23:20] : direction_ports[19:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            lfsr_reg    <= 16'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (state_reg == ST_EVAL && cnt_reg != '0 && !ordered) begin
                lfsr_reg <= lfsr_nxt;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            set_mem[clr_idx_reg] <= '0;
            if (32'(clr_idx_reg) < NUM_LINKS) begin
                wt_mem[clr_idx_reg[LW-1:0]] <= '0;
            end
        end else if (q_pop && q_head.kind == CMD_WR_SET) begin
            set_mem[AW'(32'(q_head.vnet) * NUM_LINKS + 32'(q_head.link))] <=
                q_head.dest_set[DEST_BITS-1:0];
        end else if (q_pop && q_head.kind == CMD_WR_WT) begin
            wt_mem[LW'(q_head.link)] <= q_head.weight;
        end
        set_rd_reg <= set_mem[rd_addr];
        wt_rd_reg  <= wt_mem[scan_idx_reg[LW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg      <= q_head;
            scan_idx_reg <= '0;
            proc_vld_reg <= 1'b0;
            min_reg      <= 9'd256;
            cnt_reg      <= '0;
        end else if (scanning) begin
            proc_vld_reg <= scan_issue;
            proc_idx_reg <= scan_idx_reg[LW-1:0];
            if (scan_issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (state_reg == ST_SCAN1 && hit) begin
            if ({1'b0, wt_rd_reg} < min_reg) begin
                min_reg   <= {1'b0, wt_rd_reg};
                cnt_reg   <= NW'(1);
                first_reg <= proc_idx_reg;
            end else if ({1'b0, wt_rd_reg} == min_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (state_reg == ST_EVAL) begin
            res_port_reg <= (cnt_reg == '0) ? 4'd0 : 4'(first_reg);
            res_nr_reg   <= cnt_reg == '0;
        end
        if (state_reg == ST_PICK && div_done) begin
            pick_reg     <= NW'(div_rem);
            k_reg        <= '0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
            proc_vld_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN2 && hit_min) begin
            k_reg <= k_reg + 1'b1;
            if (!found_reg && k_reg == pick_reg) begin
                found_reg    <= 1'b1;
                res_port_reg <= 4'(proc_idx_reg);
                res_nr_reg   <= 1'b0;
            end
        end
        if (state_reg == ST_DIV1 && div_done) begin
            q1_reg <= div_quo[7:0];
            r1_reg <= div_rem;
        end
        if (state_reg == ST_DIV2 && div_done) begin
            res_port_reg <= dir_port;
            res_nr_reg   <= 1'b0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_port_reg <= res_port_reg;
            m_nr_reg   <= res_nr_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_port = m_port_reg;
    assign m_no_route = m_nr_reg;

    `NRPS_ASSERT_IMP(a_pick_found, aclk, aresetn,
        (state_reg == ST_SCAN2) && scan_done, found_reg)
    `NRPS_ASSERT_IMP(a_no_pop_clear, aclk, aresetn, state_reg == ST_CLEAR, !q_pop)
    `NRPS_ASSERT_IMP(a_min_valid, aclk, aresetn,
        (state_reg == ST_EVAL) && (cnt_reg != '0), !min_reg[8])
    `NRPS_ASSERT_IMP(a_lfsr_live, aclk, aresetn, 1'b1, lfsr_reg != 16'd0)
    `NRPS_ASSERT_NXT(a_result_load, aclk, aresetn,
        (state_reg == ST_OUT) && out_free, m_valid_reg)

endmodule

FILE: hw/rtl/noc_router_output_port_select_top.sv
// Output port selection for a network-on-chip router.
// Requests enter on the s_ channel (valid/ready). Op 1 and op 2 requests load
// the per-vnet link destination sets and the link weights; op 0 requests route
// a packet and produce exactly one result on the m_ channel (valid/ready).
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata;
// the user is to write them only while the block is idle; the block does not enforce this.
// After reset the unit clears its destination-set store and link weights, one entry per cycle,
// over all NUM_VNETS*NUM_LINKS entries; s_ready stays low during that sweep.
// A two-entry request queue separates acceptance from execution. A table route
// scans the active links through the store's single read port; when the vnet is
// unordered and a link matches, it uses a 16-step divider for the random pick
// and scans the links a second time to find the picked link. XY and ring
// routes use the divider twice.
// Results sit in an output register; while the receiver stalls, the next
// request still runs up to the point of delivering its own result.
module noc_router_output_port_select_top import nrps_pkg::*; #(
    parameter int NUM_VNETS = NUM_VNETS_DEF,
    parameter int NUM_LINKS = NUM_LINKS_DEF,
    parameter int DEST_BITS = DEST_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [1:0]  s_vnet,
    input  logic [3:0]  s_link,
    input  logic [63:0] s_dest_set,
    input  logic [7:0]  s_weight,
    input  logic [7:0]  s_dst_node,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_out_port,
    output logic        m_no_route
);

    logic [1:0]   routing_mode_reg;
    logic [7:0]   node_id_reg;
    logic [7:0]   mesh_columns_reg;
    logic [8:0]   ring_size_reg;
    logic [3:0]   ordered_vnets_reg;
    logic [4:0]   links_in_use_reg;
    logic [23:0]  direction_ports_reg;

    back_status_t back_status;
    logic         q_full;
    logic         q_push;
    cmd_t         q_cmd;
    logic         q_pop;
    logic         q_valid;
    cmd_t         q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            routing_mode_reg    <= MODE_TABLE;
            node_id_reg         <= 8'd0;
            mesh_columns_reg    <= 8'd1;
            ring_size_reg       <= 9'd1;
            ordered_vnets_reg   <= 4'd0;
            links_in_use_reg    <= 5'd0;
            direction_ports_reg <= 24'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROUTING_MODE:    routing_mode_reg    <= cfg_wdata[1:0];
                REG_NODE_ID:         node_id_reg         <= cfg_wdata[7:0];
                REG_MESH_COLUMNS:    mesh_columns_reg    <= cfg_wdata[7:0];
                REG_RING_SIZE:       ring_size_reg       <= cfg_wdata[8:0];
                REG_ORDERED_VNETS:   ordered_vnets_reg   <= cfg_wdata[3:0];
                REG_LINKS_IN_USE:    links_in_use_reg    <= cfg_wdata[4:0];
                REG_DIRECTION_PORTS: direction_ports_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    nrps_front #(
        .NUM_VNETS (NUM_VNETS),
        .NUM_LINKS (NUM_LINKS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_vnet        (s_vnet),
        .s_link        (s_link),
        .s_dest_set    (s_dest_set),
        .s_weight      (s_weight),
        .s_dst_node    (s_dst_node),
        .routing_mode  (routing_mode_reg),
        .node_id       (node_id_reg),
        .back_status   (back_status),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    nrps_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .valid    (q_valid),
        .full     (q_full),
        .head     (q_head)
    );

    nrps_back #(
        .NUM_VNETS (NUM_VNETS),
        .NUM_LINKS (NUM_LINKS),
        .DEST_BITS (DEST_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .back_status     (back_status),
        .node_id         (node_id_reg),
        .mesh_columns    (mesh_columns_reg),
        .ring_size       (ring_size_reg),
        .ordered_vnets   (ordered_vnets_reg),
        .links_in_use    (links_in_use_reg),
        .direction_ports (direction_ports_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_port      (m_out_port),
        .m_no_route      (m_no_route)
    );

endmodule

FILE: verif/testbench.sv
module testbench import nrps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINKS = 16;
    localparam int VNETS = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [1:0]  s_vnet = '0;
    logic [3:0]  s_link = '0;
    logic [63:0] s_dest_set = '0;
    logic [7:0]  s_weight = '0;
    logic [7:0]  s_dst_node = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_out_port;
    logic        m_no_route;

    typedef struct packed {
        logic [3:0] out_port;
        logic       no_route;
    } route_result_t;

    logic [1:0]  mode_q;
    logic [7:0]  my_id_q;
    logic [7:0]  columns_q;
    logic [8:0]  ring_q;
    logic [3:0]  ordered_q;
    logic [4:0]  active_links_q;
    logic [23:0] dir_ports_q;
    logic [63:0] dest_sets_q [VNETS*LINKS];
    logic [7:0]  weights_q [LINKS];
    logic [15:0] lfsr_q;

    route_result_t expected_routes [$];
    int mismatches = 0;
    int long_rx_stall = 0;

    noc_router_output_port_select_top u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [3:0] port_of(int slot);
        return dir_ports_q[4*slot +: 4];
    endfunction

    function automatic route_result_t lookup_table(logic [1:0] vn, logic [63:0] dests);
        route_result_t r;
        int n, minw, count, pick;
        logic hit;
        n = (active_links_q > LINKS) ? LINKS : active_links_q;
        minw = 256;
        count = 0;
        r.out_port = '0;
        r.no_route = 1'b1;
        for (int i = 0; i < n; i++) begin
            hit = (dests & dest_sets_q[vn*LINKS + i]) != 0;
            if (hit && weights_q[i] < minw) minw = weights_q[i];
        end
        for (int i = 0; i < n; i++) begin
            hit = (dests & dest_sets_q[vn*LINKS + i]) != 0;
            if (hit && weights_q[i] == minw) count++;
        end
        if (count == 0) return r;
        pick = 0;
        if (!ordered_q[vn]) begin
            lfsr_q = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
            pick = lfsr_q % count;
        end
        for (int i = 0; i < n; i++) begin
            hit = (dests & dest_sets_q[vn*LINKS + i]) != 0;
            if (hit && weights_q[i] == minw) begin
                if (pick == 0) begin
                    r.out_port = i[3:0];
                    r.no_route = 1'b0;
                    return r;
                end
                pick--;
            end
        end
        return r;
    endfunction

    function automatic route_result_t select_port(logic [1:0] vn, logic [63:0] dests,
                                                  logic [7:0] dest);
        route_result_t r;
        int cols, mx, my, dx, dy, rn, me, d, cw, ccw;
        r.no_route = 1'b0;
        if (dest == my_id_q || mode_q == MODE_TABLE || mode_q == MODE_SPARE) begin
            r = lookup_table(vn, dests);
        end else if (mode_q == MODE_XY) begin
            cols = (columns_q == 0) ? 1 : columns_q;
            mx = my_id_q % cols;
            my = my_id_q / cols;
            dx = dest % cols;
            dy = dest / cols;
            if (dx != mx) r.out_port = (dx > mx) ? port_of(0) : port_of(1);
            else r.out_port = (dy >= my) ? port_of(2) : port_of(3);
        end else begin
            rn = (ring_q == 0) ? 1 : ring_q;
            me = my_id_q % rn;
            d = dest % rn;
            cw = (d + rn - me) % rn;
            ccw = (me + rn - d) % rn;
            r.out_port = (cw <= ccw) ? port_of(5) : port_of(4);
        end
        return r;
    endfunction

    task automatic idle_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return;
        s_valid <= 1'b0;
        repeat ((k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge aclk);
    endtask

    task automatic send_request(logic [1:0] op, logic [1:0] vn, logic [3:0] lk,
                                logic [63:0] dests, logic [7:0] wt, logic [7:0] dest);
        s_valid <= 1'b1;
        s_op <= op;
        s_vnet <= vn;
        s_link <= lk;
        s_dest_set <= dests;
        s_weight <= wt;
        s_dst_node <= dest;
        do @(posedge aclk); while (!s_ready);
        case (op)
            OP_ROUTE: expected_routes.insert(expected_routes.size(),
                                             select_port(vn, dests, dest));
            OP_WR_SET: dest_sets_q[vn*LINKS + lk] = dests;
            OP_WR_WT: weights_q[lk] = wt;
            default: ;
        endcase
        if ($urandom_range(0, 1)) begin
            idle_gap();
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_routes.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROUTING_MODE: mode_q = val[1:0];
            REG_NODE_ID: my_id_q = val[7:0];
            REG_MESH_COLUMNS: columns_q = val[7:0];
            REG_RING_SIZE: ring_q = val[8:0];
            REG_ORDERED_VNETS: ordered_q = val[3:0];
            REG_LINKS_IN_USE: active_links_q = val[4:0];
            REG_DIRECTION_PORTS: dir_ports_q = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_set();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = 64'd1 << $urandom_range(0, 63);
            1: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_config();
        write_reg(REG_ROUTING_MODE, 24'($urandom_range(0, 3)));
        write_reg(REG_NODE_ID, 24'($urandom_range(0, 255)));
        write_reg(REG_MESH_COLUMNS, 24'($urandom_range(0, 255)));
        write_reg(REG_RING_SIZE, 24'($urandom_range(0, 511)));
        write_reg(REG_ORDERED_VNETS, 24'($urandom_range(0, 15)));
        write_reg(REG_LINKS_IN_USE, 24'($urandom_range(0, 31)));
        write_reg(REG_DIRECTION_PORTS, 24'($urandom));
    endtask

    task automatic test_directed_table();
        write_reg(REG_LINKS_IN_USE, 24'd16);
        write_reg(REG_ORDERED_VNETS, 24'hF);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'd0);
        send_request(OP_WR_SET, 2'd3, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'd0);
        send_request(OP_WR_SET, 2'd3, 4'd2, 64'h8000_0000_0000_0001, 8'd0, 8'd0);
        send_request(OP_WR_WT, 2'd0, 4'd15, 64'd0, 8'd255, 8'd0);
        send_request(OP_WR_WT, 2'd0, 4'd2, 64'd0, 8'd255, 8'd0);
        send_request(OP_ROUTE, 2'd3, 4'd0, 64'h1, 8'd0, 8'd0);
        send_request(OP_ROUTE, 2'd3, 4'd0, 64'h2, 8'd0, 8'd0);
        send_request(OP_NONE, 2'd3, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF);
        drain();
        write_reg(REG_ORDERED_VNETS, 24'h0);
        send_request(OP_ROUTE, 2'd3, 4'd0, 64'h8000_0000_0000_0000, 8'd0, 8'd0);
        send_request(OP_ROUTE, 2'd3, 4'd0, 64'h8000_0000_0000_0000, 8'd0, 8'd0);
        send_request(OP_ROUTE, 2'd1, 4'd0, 64'h8000_0000_0000_0000, 8'd0, 8'd0);
        drain();
    endtask

    task automatic test_directed_xy_ring();
        write_reg(REG_DIRECTION_PORTS, 24'hFEDCBA);
        write_reg(REG_ROUTING_MODE, 24'(MODE_XY));
        write_reg(REG_MESH_COLUMNS, 24'd0);
        write_reg(REG_NODE_ID, 24'd5);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd255);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd0);
        send_request(OP_ROUTE, 2'd3, 4'd0, 64'h8000_0000_0000_0001, 8'd0, 8'd5);
        drain();
        write_reg(REG_MESH_COLUMNS, 24'd255);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd255);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd0);
        drain();
        write_reg(REG_ROUTING_MODE, 24'(MODE_RING));
        write_reg(REG_RING_SIZE, 24'd0);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd7);
        drain();
        write_reg(REG_RING_SIZE, 24'd256);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd133);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd255);
        drain();
        write_reg(REG_RING_SIZE, 24'd4);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd7);
        send_request(OP_ROUTE, 2'd0, 4'd0, 64'd1, 8'd0, 8'd9);
        drain();
    endtask

    task automatic test_random_traffic();
        int k;
        for (int phase = 0; phase < 26; phase++) begin
            random_config();
            if (phase % 3 == 0) write_reg(REG_LINKS_IN_USE, 24'($urandom_range(1, 16)));
            for (int i = 0; i < 50; i++) begin
                k = $urandom_range(0, 99);
                if (k < 55)
                    send_request(OP_ROUTE, 2'($urandom), 4'($urandom), rand_set(),
                                 8'($urandom),
                                 ($urandom_range(0, 3) == 0) ? my_id_q : 8'($urandom));
                else if (k < 80)
                    send_request(OP_WR_SET, 2'($urandom), 4'($urandom), rand_set(),
                                 8'($urandom), 8'($urandom));
                else if (k < 97)
                    send_request(OP_WR_WT, 2'($urandom), 4'($urandom), 64'($urandom),
                                 8'($urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 7)),
                                 8'($urandom));
                else
                    send_request(OP_NONE, 2'($urandom), 4'($urandom), rand_set(),
                                 8'($urandom), 8'($urandom));
            end
            drain();
        end
    endtask

    always @(posedge aclk) begin
        route_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_routes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result port=%0d no_route=%0b",
                                               m_out_port, m_no_route);
            end else begin
                want = expected_routes.pop_front();
                if (want.out_port !== m_out_port || want.no_route !== m_no_route) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("route mismatch: expected port=%0d no_route=%0b, got %0d %0b",
                                 want.out_port, want.no_route, m_out_port, m_no_route);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (long_rx_stall > 0) begin
            long_rx_stall <= long_rx_stall - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            long_rx_stall <= $urandom_range(10, 60);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        mode_q = MODE_TABLE;
        my_id_q = '0;
        columns_q = 8'd1;
        ring_q = 9'd1;
        ordered_q = '0;
        active_links_q = '0;
        dir_ports_q = '0;
        foreach (dest_sets_q[i]) dest_sets_q[i] = '0;
        foreach (weights_q[i]) weights_q[i] = '0;
        lfsr_q = 16'd1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_table();
        test_directed_xy_ring();
        test_random_traffic();
        if (mismatches == 0 && expected_routes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
